// ===== sv/amee_pkg.sv =====
// Shared types, command codes and the arctangent table for the affine matrix edit engine.
package amee_pkg;

    localparam logic [2:0] CMD_TRANS_INT = 3'd0;
    localparam logic [2:0] CMD_TRANS_EXT = 3'd1;
    localparam logic [2:0] CMD_SCALE_INT = 3'd2;
    localparam logic [2:0] CMD_SCALE_EXT = 3'd3;
    localparam logic [2:0] CMD_ROT_INT   = 3'd4;
    localparam logic [2:0] CMD_ROT_EXT   = 3'd5;
    localparam logic [2:0] CMD_IDENTITY  = 3'd6;
    localparam logic [2:0] CMD_READ      = 3'd7;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam int NUM_ENTRIES = 12;
    localparam logic [3:0] LAST_ENTRY = 4'd11;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [1:0]         axis;
        logic signed [31:0] amount;
        logic signed [15:0] angle;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic               last;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_MUL1,
        ST_MUL2,
        ST_WR_P,
        ST_MUL3,
        ST_WR_Q,
        ST_READ,
        ST_READ_WAIT
    } state_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/amee_cordic.sv =====
// Iterative CORDIC that turns an angle into cosine and sine, one rotation per cycle.
module amee_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    input  logic               negate,
    output logic               done,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    localparam int CW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(ITERATIONS - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               flip_reg, flip_next;

    logic [31:0]        z_start;
    logic [31:0]        z_turned;
    logic               flip_start;
    logic signed [33:0] dx, dy, step_angle;
    logic signed [33:0] x_round, y_round;

    always_comb
    begin
        z_start = {angle, 16'h0000};
        if (negate)
        begin
            z_start = 32'h0 - z_start;
        end
        // Angles in the left half-plane are turned by half a turn and negated at the end.
        flip_start = (z_start[31:30] == 2'b01) || (z_start[31:30] == 2'b10);
        z_turned   = flip_start ? (z_start + 32'h8000_0000) : z_start;
    end

    always_comb
    begin
        dx         = y_reg >>> cnt_reg;
        dy         = x_reg >>> cnt_reg;
        step_angle = signed'({2'b00, amee_pkg::atan_entry(5'(cnt_reg))});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = amee_pkg::CORDIC_K;
            y_next    = '0;
            z_next    = signed'({{2{z_turned[31]}}, z_turned});
            flip_next = flip_start;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_angle;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_angle;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    always_comb
    begin
        x_round = (x_reg + 34'sd8192) >>> 14;
        y_round = (y_reg + 34'sd8192) >>> 14;
        if (flip_reg)
        begin
            x_round = -x_round;
            y_round = -y_round;
        end
        cos_val = 32'(x_round);
        sin_val = 32'(y_round);
    end

    assign done = done_reg;

endmodule

// ===== sv/amee_mac.sv =====
// Shared multiplier with a product and an accumulator register, rounding and saturation.
module amee_mac #(
    parameter int EW = 32
) (
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    input  logic signed [31:0] addend,
    output logic signed [31:0] result
);

    localparam logic signed [65:0] EMAX = (66'sd1 <<< (EW - 1)) - 66'sd1;
    localparam logic signed [65:0] EMIN = -EMAX - 66'sd1;

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [65:0] sum;
    logic signed [65:0] total;

    // The product of one cycle moves to the accumulator in the next, so two
    // consecutive products can be summed and rounded once.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= prod_reg;
    end

    always_comb
    begin
        sum   = 66'(acc_reg) + 66'(prod_reg);
        total = ((sum + 66'sd32768) >>> 16) + 66'(addend);
        if (total > EMAX)
        begin
            result = 32'(EMAX);
        end
        else if (total < EMIN)
        begin
            result = 32'(EMIN);
        end
        else
        begin
            result = 32'(total);
        end
    end

endmodule

// ===== sv/affine_matrix_edit_engine.sv =====
// Top level of the affine matrix edit engine: matrix storage, sequencer and read stream.
//
//  Channel    Direction  Payload                     Handshake
//  cmd        in         amee_pkg::cmd_t cmd_data    cmd_valid / cmd_ready
//  rsp        out        amee_pkg::entry_t rsp_data  rsp_valid / rsp_ready
//
// One command is taken at a time; cmd_ready is high only while the sequencer is idle.
// Identity and commands on axis three leave the sequencer idle. Translate and scale
// pass each entry through the shared multiplier in turn. A rotation first waits for
// the CORDIC, then updates the matrix one entry pair at a time.
// A read sends 12 transfers, one per cycle while rsp_ready stays high; a stalled
// output holds its entry and the stream resumes where it stopped.
// Reset loads the identity matrix and returns the sequencer to idle.
module affine_matrix_edit_engine #(
    parameter int ENTRY_WIDTH     = 32,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  amee_pkg::cmd_t   cmd_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output amee_pkg::entry_t rsp_data
);

    localparam int EW = (ENTRY_WIDTH > 32) ? 32 : ((ENTRY_WIDTH < 16) ? 16 : ENTRY_WIDTH);
    localparam int NITER = (TRIG_ITERATIONS > 32) ? 32 :
                           ((TRIG_ITERATIONS < 1) ? 1 : TRIG_ITERATIONS);
    // 1.0 saturates when the entries are too narrow to hold it.
    localparam logic signed [31:0] ONE_SAT = (EW > 17) ? amee_pkg::ONE_Q16 :
                                             32'((64'sd1 <<< (EW - 1)) - 64'sd1);

    amee_pkg::state_t state_reg, state_next;

    logic signed [31:0] ent_reg [amee_pkg::NUM_ENTRIES];
    logic [2:0]         op_reg;
    logic [1:0]         axis_reg;
    logic signed [31:0] amount_reg;
    logic [1:0]         k_reg, k_next;
    logic [3:0]         idx_reg, idx_next;
    logic signed [31:0] a_reg, b_reg;
    logic signed [31:0] c_reg, s_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    amee_pkg::entry_t   rsp_data_reg;

    logic               accept;
    logic               is_rot, is_ext;
    logic [1:0]         p_sel, q_sel;
    logic [1:0]         k_last;
    logic [3:0]         ia, ib, rd_addr, wr_addr;
    logic signed [31:0] rd_word;
    logic signed [31:0] mul_a, mul_b, addend, mac_result;
    logic               trig_done;
    logic signed [31:0] trig_cos, trig_sin;

    typedef struct packed {
        logic ready;
        logic ld_a;
        logic ld_b;
        logic wr_p;
        logic wr_q;
        logic rd_load;
    } ctrl_t;

    ctrl_t ctrl;

    function automatic logic [3:0] ent_index(input logic [1:0] col, input logic [1:0] row);
        return 4'({col, 1'b0}) + 4'(col) + 4'(row);
    endfunction

    assign accept = cmd_valid && cmd_ready;
    assign is_rot = (op_reg == amee_pkg::CMD_ROT_INT) || (op_reg == amee_pkg::CMD_ROT_EXT);
    assign is_ext = (op_reg == amee_pkg::CMD_ROT_EXT);
    assign p_sel  = (axis_reg == amee_pkg::AXIS_X) ? 2'd1 : 2'd0;
    assign q_sel  = (axis_reg == amee_pkg::AXIS_Z) ? 2'd1 : 2'd2;

    // Entry addresses of the two operands for step k; the first is written on the
    // first write, the second on the second write of a rotation.
    always_comb
    begin
        ia     = ent_index(axis_reg, k_reg);
        ib     = ent_index(2'd3, k_reg);
        k_last = 2'd2;
        case (op_reg)
            amee_pkg::CMD_TRANS_EXT:
            begin
                ia     = ent_index(2'd3, axis_reg);
                k_last = 2'd0;
            end
            amee_pkg::CMD_SCALE_EXT:
            begin
                ia     = ent_index(k_reg, axis_reg);
                k_last = 2'd3;
            end
            amee_pkg::CMD_ROT_INT:
            begin
                ia = ent_index(p_sel, k_reg);
                ib = ent_index(q_sel, k_reg);
            end
            amee_pkg::CMD_ROT_EXT:
            begin
                ia     = ent_index(k_reg, p_sel);
                ib     = ent_index(k_reg, q_sel);
                k_last = 2'd3;
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amee_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_data.cmd == amee_pkg::CMD_READ)
                    begin
                        state_next = amee_pkg::ST_READ;
                    end
                    else if ((cmd_data.cmd == amee_pkg::CMD_IDENTITY) ||
                             (cmd_data.axis == amee_pkg::AXIS_NONE))
                    begin
                        state_next = amee_pkg::ST_IDLE;
                    end
                    else if ((cmd_data.cmd == amee_pkg::CMD_ROT_INT) ||
                             (cmd_data.cmd == amee_pkg::CMD_ROT_EXT))
                    begin
                        state_next = amee_pkg::ST_TRIG;
                    end
                    else
                    begin
                        state_next = amee_pkg::ST_LOAD_A;
                    end
                end
            end
            amee_pkg::ST_TRIG:
            begin
                if (trig_done)
                begin
                    state_next = amee_pkg::ST_LOAD_A;
                end
            end
            amee_pkg::ST_LOAD_A: state_next = amee_pkg::ST_LOAD_B;
            amee_pkg::ST_LOAD_B: state_next = amee_pkg::ST_MUL1;
            amee_pkg::ST_MUL1:   state_next = amee_pkg::ST_MUL2;
            amee_pkg::ST_MUL2:   state_next = amee_pkg::ST_WR_P;
            amee_pkg::ST_WR_P:
            begin
                if (is_rot)
                begin
                    state_next = amee_pkg::ST_MUL3;
                end
                else if (k_reg == k_last)
                begin
                    state_next = amee_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = amee_pkg::ST_LOAD_A;
                end
            end
            amee_pkg::ST_MUL3: state_next = amee_pkg::ST_WR_Q;
            amee_pkg::ST_WR_Q:
            begin
                state_next = (k_reg == k_last) ? amee_pkg::ST_IDLE : amee_pkg::ST_LOAD_A;
            end
            amee_pkg::ST_READ:
            begin
                if (ctrl.rd_load && (idx_reg == amee_pkg::LAST_ENTRY))
                begin
                    state_next = amee_pkg::ST_READ_WAIT;
                end
            end
            amee_pkg::ST_READ_WAIT:
            begin
                if (rsp_ready)
                begin
                    state_next = amee_pkg::ST_IDLE;
                end
            end
            default: state_next = amee_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            amee_pkg::ST_IDLE:   ctrl.ready = 1'b1;
            amee_pkg::ST_LOAD_A: ctrl.ld_a = 1'b1;
            amee_pkg::ST_LOAD_B: ctrl.ld_b = 1'b1;
            amee_pkg::ST_WR_P:   ctrl.wr_p = 1'b1;
            amee_pkg::ST_WR_Q:   ctrl.wr_q = 1'b1;
            amee_pkg::ST_READ:   ctrl.rd_load = !rsp_valid_reg || rsp_ready;
            default:
            begin
            end
        endcase
    end

    assign cmd_ready = ctrl.ready;

    // Operand selection for the shared multiplier. A first write stores the summed
    // products of MUL1 and MUL2, a second write those of the first write and MUL3.
    always_comb
    begin
        mul_a = a_reg;
        mul_b = '0;
        case (state_reg)
            amee_pkg::ST_MUL1:
            begin
                if (is_rot)
                begin
                    mul_b = c_reg;
                end
                else if (op_reg == amee_pkg::CMD_TRANS_EXT)
                begin
                    mul_b = amee_pkg::ONE_Q16;
                end
                else
                begin
                    mul_b = amount_reg;
                end
            end
            amee_pkg::ST_MUL2:
            begin
                mul_a = b_reg;
                if (is_rot)
                begin
                    mul_b = is_ext ? -s_reg : s_reg;
                end
            end
            amee_pkg::ST_WR_P:
            begin
                mul_a = b_reg;
                mul_b = c_reg;
            end
            amee_pkg::ST_MUL3:
            begin
                mul_b = is_ext ? s_reg : -s_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        addend = '0;
        if (ctrl.wr_p)
        begin
            if (op_reg == amee_pkg::CMD_TRANS_INT)
            begin
                addend = b_reg;
            end
            else if (op_reg == amee_pkg::CMD_TRANS_EXT)
            begin
                addend = amount_reg;
            end
        end
    end

    assign rd_addr = ctrl.ld_a ? ia : (ctrl.ld_b ? ib : idx_reg);
    assign rd_word = ent_reg[rd_addr];
    assign wr_addr = ctrl.wr_q ? ib : ((op_reg == amee_pkg::CMD_TRANS_INT) ? ib : ia);

    amee_mac #(
        .EW(EW)
    ) u_mac (
        .clk    (clk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .addend (addend),
        .result (mac_result)
    );

    amee_cordic #(
        .ITERATIONS(NITER)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && ((cmd_data.cmd == amee_pkg::CMD_ROT_INT) ||
                             (cmd_data.cmd == amee_pkg::CMD_ROT_EXT))
                         && (cmd_data.axis != amee_pkg::AXIS_NONE)),
        .angle   (cmd_data.angle),
        .negate  (cmd_data.axis == amee_pkg::AXIS_Y),
        .done    (trig_done),
        .cos_val (trig_cos),
        .sin_val (trig_sin)
    );

    always_comb
    begin
        k_next = k_reg;
        if (accept)
        begin
            k_next = '0;
        end
        else if ((ctrl.wr_p && !is_rot) || ctrl.wr_q)
        begin
            k_next = k_reg + 1'b1;
        end
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = '0;
        end
        else if (ctrl.rd_load)
        begin
            idx_next = idx_reg + 1'b1;
        end
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.rd_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amee_pkg::ST_IDLE;
            k_reg         <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Matrix storage: identity at reset and on the identity command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < amee_pkg::NUM_ENTRIES; i++)
            begin
                ent_reg[i] <= ((i == 0) || (i == 4) || (i == 8)) ? ONE_SAT : '0;
            end
        end
        else if (accept && (cmd_data.cmd == amee_pkg::CMD_IDENTITY))
        begin
            for (int i = 0; i < amee_pkg::NUM_ENTRIES; i++)
            begin
                ent_reg[i] <= ((i == 0) || (i == 4) || (i == 8)) ? ONE_SAT : '0;
            end
        end
        else if (ctrl.wr_p || ctrl.wr_q)
        begin
            ent_reg[wr_addr] <= mac_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd_data.cmd;
            axis_reg   <= cmd_data.axis;
            amount_reg <= cmd_data.amount;
        end
        if (ctrl.ld_a)
        begin
            a_reg <= rd_word;
        end
        if (ctrl.ld_b)
        begin
            b_reg <= rd_word;
        end
        if (trig_done)
        begin
            c_reg <= trig_cos;
            s_reg <= trig_sin;
        end
        if (ctrl.rd_load)
        begin
            rsp_data_reg.entry_index <= idx_reg;
            rsp_data_reg.entry_value <= rd_word;
            rsp_data_reg.last        <= (idx_reg == amee_pkg::LAST_ENTRY);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_rsp_only_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((state_reg == amee_pkg::ST_READ) ||
                       (state_reg == amee_pkg::ST_READ_WAIT)))
        else $error("result valid outside a read run");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && rsp_valid))
        else $error("command taken while a read entry is pending");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.last) |-> (rsp_data.entry_index == amee_pkg::LAST_ENTRY))
        else $error("last flag on an entry other than the final one");

    a_identity_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_data.cmd == amee_pkg::CMD_IDENTITY))
            |=> (cmd_ready && (ent_reg[1] == '0) && (ent_reg[0] == ONE_SAT)))
        else $error("identity load did not complete in one cycle");

    a_trig_only_rot: assert property (@(posedge clk) disable iff (!rst_n)
        trig_done |-> (state_reg == amee_pkg::ST_TRIG))
        else $error("trig result outside a rotation");

endmodule
